// ----- hw/rtl/cbt_pkg.sv -----
// ---------------------------------------------------------------------------
// cbt_pkg
// Shared types, constants and helpers of the color bank table and tint unit.
// ---------------------------------------------------------------------------
package cbt_pkg;

    localparam int BANKS        = 16;
    localparam int IDX_W        = $clog2(BANKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SEL_W        = 4;
    localparam int SLOT_W       = 4;
    localparam int CMP_W        = CNT_W + SEL_W;

    localparam logic        ACT_REGISTER = 1'b0;
    localparam logic        ACT_TINT     = 1'b1;

    localparam logic [23:0] WHITE_RGB    = 24'hFF_FFFF;
    localparam logic [15:0] ROUND_BIAS   = 16'd127;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

    typedef struct packed {
        logic        action;
        logic [23:0] new_color;
        logic [3:0]  bank_select;
        logic [31:0] base_pixel;
    } req_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [31:0] tinted_pixel;
        logic        table_full;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic [7:0] chan;
        logic [7:0] tint;
    } scale_ctrl_t;

    // exact x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x >> 8) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ----- hw/rtl/cbt_scale_unit.sv -----
// ---------------------------------------------------------------------------
// cbt_scale_unit
// Shared 8x8 channel multiplier with rounding bias and divide by 255.
// ---------------------------------------------------------------------------
module cbt_scale_unit (
    input  logic                clk,
    input  cbt_pkg::scale_ctrl_t ctrl,
    output logic [7:0]          scaled
);

    logic [15:0] prod_reg;
    logic [15:0] prod_next;

    assign prod_next = 16'(16'(ctrl.chan) * 16'(ctrl.tint)) + cbt_pkg::ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign scaled = cbt_pkg::div255(prod_reg);

endmodule

// ----- hw/rtl/color_bank_table_and_tint_unit.sv -----
// ---------------------------------------------------------------------------
// color_bank_table_and_tint_unit
// Tint color table with deduplication and a per-pixel tint unit.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | cbt_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_ready  | cbt_pkg::rsp_t
//
//  one transaction at a time; req_ready is high only while the sequencer idles
//  register: white goes straight to the result, else the color is compared
//  against each used bank in turn and written to the next free bank when new
//  tint: red, green, blue through the shared channel multiplier, else pass-through
//  a result waits in the output register while rsp_ready is low
//  reset leaves only white at bank 0
// ---------------------------------------------------------------------------
module color_bank_table_and_tint_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cbt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cbt_pkg::rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int IDX_W = cbt_pkg::IDX_W;
    localparam int CNT_W = cbt_pkg::CNT_W;
    localparam int CMP_W = cbt_pkg::CMP_W;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     addr_reg, addr_next;
    logic [1:0]           step_reg, step_next;
    logic [23:0]          color_reg, color_next;
    logic [31:0]          pixel_reg, pixel_next;
    logic [23:0]          rgb_reg, rgb_next;
    cbt_pkg::rsp_t        res_reg, res_next;
    cbt_pkg::rsp_t        rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [23:0]          bank_mem [cbt_pkg::BANKS];
    logic [23:0]          rd_color_reg;
    logic                 wr_en;

    logic                 accept;
    logic                 sel_used;
    logic                 out_free;
    cbt_pkg::scale_ctrl_t scale_ctrl;
    logic [7:0]           scaled;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign sel_used  = (req.bank_select != '0)
                       && (CMP_W'(req.bank_select) < CMP_W'(count_reg));

    // channel operands, red first
    always_comb
    begin
        scale_ctrl.load = (state_reg == ST_MUL) && (step_reg != 2'd3);
        case (step_reg)
            2'd0:
            begin
                scale_ctrl.chan = pixel_reg[23:16];
                scale_ctrl.tint = rd_color_reg[23:16];
            end
            2'd1:
            begin
                scale_ctrl.chan = pixel_reg[15:8];
                scale_ctrl.tint = rd_color_reg[15:8];
            end
            default:
            begin
                scale_ctrl.chan = pixel_reg[7:0];
                scale_ctrl.tint = rd_color_reg[7:0];
            end
        endcase
    end

    cbt_scale_unit u_scale (
        .clk    (clk),
        .ctrl   (scale_ctrl),
        .scaled (scaled)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        color_next     = color_reg;
        pixel_next     = pixel_reg;
        rgb_next       = rgb_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    color_next = req.new_color;
                    pixel_next = req.base_pixel;
                    res_next   = '0;
                    step_next  = '0;
                    if (req.action == cbt_pkg::ACT_REGISTER)
                    begin
                        addr_next = CNT_W'(1);
                        if (req.new_color == cbt_pkg::WHITE_RGB)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        addr_next = CNT_W'(req.bank_select);
                        if (sel_used)
                        begin
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            res_next.tinted_pixel = req.base_pixel;
                            state_next            = ST_DONE;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == count_reg)
                begin
                    if (count_reg == CNT_W'(cbt_pkg::BANKS))
                    begin
                        res_next.table_full = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        res_next.slot = cbt_pkg::SLOT_W'(count_reg[IDX_W-1:0]);
                        count_next    = count_reg + CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
                else if (rd_color_reg == color_reg)
                begin
                    res_next.slot = cbt_pkg::SLOT_W'(addr_reg[IDX_W-1:0]);
                    state_next    = ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + CNT_W'(1);
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg != 2'd0)
                begin
                    rgb_next = {rgb_reg[15:0], scaled};
                end
                if (step_reg == 2'd3)
                begin
                    res_next.tinted_pixel = cbt_pkg::ALPHA_OPAQUE | {8'h00, rgb_next};
                    state_next            = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        step_reg  <= step_next;
        color_reg <= color_next;
        pixel_reg <= pixel_next;
        rgb_reg   <= rgb_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    // read follows the next address so the data lines up with addr_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[count_reg[IDX_W-1:0]] <= color_reg;
        end
        rd_color_reg <= bank_mem[addr_next[IDX_W-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(cbt_pkg::BANKS)))
        else $error("bank count out of range");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> count_reg == CNT_W'(cbt_pkg::BANKS))
        else $error("table full reported with free entries");

    a_full_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> rsp.slot == '0 && rsp.tinted_pixel == '0)
        else $error("table full result carries data");

    a_mul_bank_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> addr_reg != '0 && addr_reg < count_reg)
        else $error("tint reads an unused bank");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction taken while busy");
`endif

endmodule
